// ===== design/wsd_pkg.sv =====
// Package for the WebSocket frame deframer: parser phase type, result kinds,
// opcodes, error codes and the result record. No dependencies.
`default_nettype none

package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HEAD0 = 3'd0,
      PH_HEAD1 = 3'd1,
      PH_EXT   = 3'd2,
      PH_KEY   = 3'd3,
      PH_PAY   = 3'd4,
      PH_ERR   = 3'd5
   } phase_type;

   localparam logic [2:0] KIND_DATA  = 3'd0;
   localparam logic [2:0] KIND_END   = 3'd1;
   localparam logic [2:0] KIND_PING  = 3'd2;
   localparam logic [2:0] KIND_CLOSE = 3'd3;
   localparam logic [2:0] KIND_ERROR = 3'd4;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OPCODE    = 2'd1;
   localparam logic [1:0] ERR_PING_LONG = 2'd2;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [6:0]  LEN7_EXT16     = 7'd126;
   localparam logic [6:0]  LEN7_EXT64     = 7'd127;
   localparam logic [15:0] CLOSE_DEFAULT  = 16'd1000;
   localparam logic [6:0]  LIMIT_RESET    = 7'd125;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic        is_binary;
      logic        is_continuation;
      logic        more_fragments;
      logic        frame_last;
      logic [15:0] close_reason;
      logic [1:0]  error_code;
   } result_type;

endpackage

`default_nettype wire

// ===== design/wsd_core.sv =====
// Frame header parser and payload unmasker: holds the per-frame state and
// forms at most one result per accepted byte. Depends on wsd_pkg.
`default_nettype none

module wsd_core #(
   parameter int LEN_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           rx_byte,
   input  wire logic [6:0]           limit,
   output logic                      res_valid,
   output wsd_pkg::result_type       res
);

   wsd_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]          ext_count_ff, ext_count_in;
   logic [7:0]          head_byte_ff, head_byte_in;
   logic                mask_on_ff, mask_on_in;
   logic [LEN_BITS-1:0] remaining_ff, remaining_in;
   logic [31:0]         mask_key_ff, mask_key_in;
   logic [1:0]          mask_pos_ff, mask_pos_in;
   logic [7:0]          reason_high_ff, reason_high_in;
   logic [1:0]          reason_count_ff, reason_count_in;

   logic [3:0]          op;
   logic [6:0]          len7;
   logic                len7_ext;
   logic [LEN_BITS-1:0] len_short;
   logic [LEN_BITS-1:0] len_shift;
   logic [LEN_BITS-1:0] limit_wide;
   logic                fin_now;
   logic [LEN_BITS-1:0] fin_len;
   logic                fin_zero;
   logic                fin_lt2;
   logic                fin_ping_long;
   logic [LEN_BITS-1:0] after_len_phase_dummy;
   logic [7:0]          key_byte;
   logic [7:0]          plain;
   logic                pay_last;
   wsd_pkg::phase_type  fin_after;

   assign op         = head_byte_ff[3:0];
   assign len7       = rx_byte[6:0];
   assign len7_ext   = (len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64);
   assign len_short  = {{(LEN_BITS-7){1'b0}}, len7};
   assign len_shift  = {remaining_ff[LEN_BITS-9:0], rx_byte};
   assign limit_wide = {{(LEN_BITS-7){1'b0}}, limit};

   // The header completes on the byte that ends the length when there is no
   // key, or on the last key byte.
   always_comb begin
      fin_now = 1'b0;
      fin_len = remaining_ff;
      case (phase_ff)
         wsd_pkg::PH_HEAD1: begin
            fin_now = !len7_ext && !rx_byte[7];
            fin_len = len_short;
         end
         wsd_pkg::PH_EXT: begin
            fin_now = (ext_count_ff == 3'd0) && !mask_on_ff;
            fin_len = len_shift;
         end
         wsd_pkg::PH_KEY: begin
            fin_now = (ext_count_ff == 3'd0);
            fin_len = remaining_ff;
         end
         default: begin
            fin_now = 1'b0;
            fin_len = remaining_ff;
         end
      endcase
   end

   assign after_len_phase_dummy = fin_len;
   assign fin_zero      = (after_len_phase_dummy == '0);
   assign fin_lt2       = (fin_len[LEN_BITS-1:1] == '0);
   assign fin_ping_long = (fin_len > limit_wide);
   assign fin_after     = fin_zero ? wsd_pkg::PH_HEAD0 : wsd_pkg::PH_PAY;

   always_comb begin
      case (mask_pos_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   assign plain    = mask_on_ff ? (rx_byte ^ key_byte) : rx_byte;
   assign pay_last = (remaining_ff == LEN_BITS'(1));

   // Next state.
   always_comb begin
      phase_in        = phase_ff;
      ext_count_in    = ext_count_ff;
      head_byte_in    = head_byte_ff;
      mask_on_in      = mask_on_ff;
      remaining_in    = remaining_ff;
      mask_key_in     = mask_key_ff;
      mask_pos_in     = mask_pos_ff;
      reason_high_in  = reason_high_ff;
      reason_count_in = reason_count_ff;
      case (phase_ff)
         wsd_pkg::PH_HEAD0: begin
            head_byte_in = rx_byte;
            phase_in     = wsd_pkg::PH_HEAD1;
         end
         wsd_pkg::PH_HEAD1: begin
            mask_on_in = rx_byte[7];
            if (len7_ext) begin
               ext_count_in = (len7 == wsd_pkg::LEN7_EXT16) ? 3'd1 : 3'd7;
               remaining_in = '0;
               phase_in     = wsd_pkg::PH_EXT;
            end else begin
               remaining_in = len_short;
               if (rx_byte[7]) begin
                  ext_count_in = 3'd3;
                  phase_in     = wsd_pkg::PH_KEY;
               end
            end
         end
         wsd_pkg::PH_EXT: begin
            remaining_in = len_shift;
            if (ext_count_ff != 3'd0) begin
               ext_count_in = ext_count_ff - 3'd1;
            end else if (mask_on_ff) begin
               ext_count_in = 3'd3;
               phase_in     = wsd_pkg::PH_KEY;
            end
         end
         wsd_pkg::PH_KEY: begin
            mask_key_in = {mask_key_ff[23:0], rx_byte};
            if (ext_count_ff != 3'd0) begin
               ext_count_in = ext_count_ff - 3'd1;
            end
         end
         wsd_pkg::PH_PAY: begin
            if (remaining_ff == '0) begin
               phase_in = wsd_pkg::PH_HEAD0;
            end else begin
               if (mask_on_ff) begin
                  mask_pos_in = mask_pos_ff + 2'd1;
               end
               remaining_in = remaining_ff - LEN_BITS'(1);
               phase_in     = pay_last ? wsd_pkg::PH_HEAD0 : wsd_pkg::PH_PAY;
               if (op == wsd_pkg::OP_CLOSE) begin
                  if (reason_count_ff == 2'd0) begin
                     reason_high_in  = plain;
                     reason_count_in = 2'd1;
                  end else if (reason_count_ff == 2'd1) begin
                     reason_count_in = 2'd2;
                  end
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (fin_now) begin
         mask_pos_in     = 2'd0;
         reason_count_in = 2'd0;
         reason_high_in  = 8'd0;
         if (op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN,
                        wsd_pkg::OP_PONG}) begin
            phase_in = fin_after;
         end else if (op == wsd_pkg::OP_CLOSE) begin
            phase_in = fin_after;
            if (fin_lt2) begin
               reason_count_in = 2'd2;
            end
         end else if (op == wsd_pkg::OP_PING) begin
            phase_in = fin_ping_long ? wsd_pkg::PH_ERR : fin_after;
         end else begin
            phase_in = wsd_pkg::PH_ERR;
         end
      end
   end

   // Result for the byte being accepted.
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (fin_now) begin
         if (op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN}) begin
            if (fin_zero) begin
               res_valid           = 1'b1;
               res.kind            = wsd_pkg::KIND_END;
               res.is_binary       = (op == wsd_pkg::OP_BIN);
               res.is_continuation = (op == wsd_pkg::OP_CONT);
               res.more_fragments  = !head_byte_ff[7];
               res.frame_last      = 1'b1;
            end
         end else if (op == wsd_pkg::OP_CLOSE) begin
            if (fin_lt2) begin
               res_valid        = 1'b1;
               res.kind         = wsd_pkg::KIND_CLOSE;
               res.frame_last   = fin_zero;
               res.close_reason = wsd_pkg::CLOSE_DEFAULT;
            end
         end else if (op == wsd_pkg::OP_PING) begin
            if (fin_ping_long) begin
               res_valid      = 1'b1;
               res.kind       = wsd_pkg::KIND_ERROR;
               res.error_code = wsd_pkg::ERR_PING_LONG;
            end
         end else if (op != wsd_pkg::OP_PONG) begin
            res_valid      = 1'b1;
            res.kind       = wsd_pkg::KIND_ERROR;
            res.error_code = wsd_pkg::ERR_OPCODE;
         end
      end else if ((phase_ff == wsd_pkg::PH_PAY) && (remaining_ff != '0)) begin
         if (op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN}) begin
            res_valid           = 1'b1;
            res.kind            = wsd_pkg::KIND_DATA;
            res.data_byte       = plain;
            res.is_binary       = (op == wsd_pkg::OP_BIN);
            res.is_continuation = (op == wsd_pkg::OP_CONT);
            res.more_fragments  = !head_byte_ff[7];
            res.frame_last      = pay_last;
         end else if (op == wsd_pkg::OP_PING) begin
            res_valid      = 1'b1;
            res.kind       = wsd_pkg::KIND_PING;
            res.data_byte  = plain;
            res.frame_last = pay_last;
         end else if ((op == wsd_pkg::OP_CLOSE) && (reason_count_ff == 2'd1)) begin
            res_valid        = 1'b1;
            res.kind         = wsd_pkg::KIND_CLOSE;
            res.frame_last   = pay_last;
            res.close_reason = {reason_high_ff, plain};
         end
      end
      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= wsd_pkg::PH_HEAD0;
         ext_count_ff    <= 3'd0;
         head_byte_ff    <= 8'd0;
         mask_on_ff      <= 1'b0;
         remaining_ff    <= '0;
         mask_key_ff     <= 32'd0;
         mask_pos_ff     <= 2'd0;
         reason_high_ff  <= 8'd0;
         reason_count_ff <= 2'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         ext_count_ff    <= ext_count_in;
         head_byte_ff    <= head_byte_in;
         mask_on_ff      <= mask_on_in;
         remaining_ff    <= remaining_in;
         mask_key_ff     <= mask_key_in;
         mask_pos_ff     <= mask_pos_in;
         reason_high_ff  <= reason_high_in;
         reason_count_ff <= reason_count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsd_pkg::PH_ERR) |-> !res_valid)
      else $error("result produced while holding in error");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsd_pkg::PH_ERR) |=> (phase_ff == wsd_pkg::PH_ERR))
      else $error("left the error phase without reset");

   a_last_to_head: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.frame_last && (res.kind == wsd_pkg::KIND_DATA))
      |=> (phase_ff == wsd_pkg::PH_HEAD0))
      else $error("frame payload ended but parser not back at header");
`endif

endmodule

`default_nettype wire

// ===== design/websocket_frame_deframer_unit.sv =====
// WebSocket receive-side frame deframer, top level: handshakes, the control
// length register and the result register. Depends on wsd_pkg and wsd_core.
//
// Usage:
//   Received bytes enter on the req_ channel (req_valid / req_ready), one
//   byte per transaction. Each byte yields zero or one result on the rsp_
//   channel (rsp_valid / rsp_ready): payload bytes, empty-frame end markers,
//   ping bytes, close events and errors.
//   A result appears in the output register on the cycle after its byte is
//   taken. Throughput is one byte per cycle while req_ready is high; the
//   header parse and the XOR unmask sit between the parser state and the
//   output register.
//   req_ready is high whenever the output register is empty or is being
//   drained in the same cycle, so a stalled receiver holds the input only
//   while a result waits.
//   csr_wr_en writes csr_wr_data into the ping length limit; write it only
//   while no transaction is in flight.
//   Reset is synchronous: the parser returns to the first header byte, the
//   limit returns to 125 and the output register empties. After an error
//   the block swallows every byte until the next reset.
`default_nettype none

module websocket_frame_deframer_unit #(
   parameter int LEN_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_is_binary,
   output logic             rsp_is_continuation,
   output logic             rsp_more_fragments,
   output logic             rsp_frame_last,
   output logic [15:0]      rsp_close_reason,
   output logic [1:0]       rsp_error_code,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data
);

   logic [6:0]          limit_reg_ff;
   logic                step;
   logic                res_valid;
   wsd_pkg::result_type res;
   logic                rsp_valid_ff, rsp_valid_in;
   wsd_pkg::result_type rsp_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   wsd_core #(
      .LEN_BITS (LEN_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (req_rx_byte),
      .limit     (limit_reg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_reg_ff <= wsd_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_reg_ff <= csr_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_ff.kind;
   assign rsp_data_byte       = rsp_ff.data_byte;
   assign rsp_is_binary       = rsp_ff.is_binary;
   assign rsp_is_continuation = rsp_ff.is_continuation;
   assign rsp_more_fragments  = rsp_ff.more_fragments;
   assign rsp_frame_last      = rsp_ff.frame_last;
   assign rsp_close_reason    = rsp_ff.close_reason;
   assign rsp_error_code      = rsp_ff.error_code;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer_unit: it feeds WebSocket frames byte by
// byte, predicts each result with its own parser and checks it field by field.
// Depends on wsd_pkg and the deframer RTL only.

module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_is_binary;
   logic        rsp_is_continuation;
   logic        rsp_more_fragments;
   logic        rsp_frame_last;
   logic [15:0] rsp_close_reason;
   logic [1:0]  rsp_error_code;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = 7'd0;

   websocket_frame_deframer_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_is_binary       (rsp_is_binary),
      .rsp_is_continuation (rsp_is_continuation),
      .rsp_more_fragments  (rsp_more_fragments),
      .rsp_frame_last      (rsp_frame_last),
      .rsp_close_reason    (rsp_close_reason),
      .rsp_error_code      (rsp_error_code),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Parser state mirrored from the receive side of the protocol.
   wsd_pkg::phase_type parse_phase = wsd_pkg::PH_HEAD0;
   logic [2:0]  ext_left = '0;
   logic [7:0]  hdr0 = '0;
   logic        masked = 1'b0;
   logic [63:0] pay_left = '0;
   logic [31:0] mask_key = '0;
   logic [1:0]  key_pos = '0;
   logic [7:0]  code_hi = '0;
   logic [1:0]  code_cnt = '0;
   logic [6:0]  ping_limit = wsd_pkg::LIMIT_RESET;

   logic [7:0]  wire_bytes[$];
   wsd_pkg::result_type deframed_pending[$];
   int          bytes_queued = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;
   int          hold_req = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   function automatic wsd_pkg::result_type with_flags(wsd_pkg::result_type r,
                                                      logic [3:0] op);
      with_flags = r;
      with_flags.is_binary = (op == wsd_pkg::OP_BIN);
      with_flags.is_continuation = (op == wsd_pkg::OP_CONT);
      with_flags.more_fragments = ~hdr0[7];
   endfunction

   function automatic wsd_pkg::phase_type phase_after_length();
      phase_after_length = (pay_left != 0) ? wsd_pkg::PH_PAY : wsd_pkg::PH_HEAD0;
   endfunction

   task automatic close_header(output bit got, output wsd_pkg::result_type r);
      logic [3:0] op;
      got = 1'b0;
      r = '0;
      op = hdr0[3:0];
      key_pos = '0;
      code_cnt = '0;
      code_hi = '0;
      case (op)
         wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN: begin
            if (pay_left == 0) begin
               r.kind = wsd_pkg::KIND_END;
               r = with_flags(r, op);
               r.frame_last = 1'b1;
               got = 1'b1;
               parse_phase = wsd_pkg::PH_HEAD0;
            end else begin
               parse_phase = wsd_pkg::PH_PAY;
            end
         end
         wsd_pkg::OP_CLOSE: begin
            parse_phase = phase_after_length();
            // A close too short to carry a status code reports the default at once.
            if (pay_left < 2) begin
               r.kind = wsd_pkg::KIND_CLOSE;
               r.frame_last = (pay_left == 0);
               r.close_reason = wsd_pkg::CLOSE_DEFAULT;
               code_cnt = 2'd2;
               got = 1'b1;
            end
         end
         wsd_pkg::OP_PING: begin
            if (pay_left > {57'd0, ping_limit}) begin
               r.kind = wsd_pkg::KIND_ERROR;
               r.error_code = wsd_pkg::ERR_PING_LONG;
               got = 1'b1;
               parse_phase = wsd_pkg::PH_ERR;
            end else begin
               parse_phase = phase_after_length();
            end
         end
         wsd_pkg::OP_PONG: parse_phase = phase_after_length();
         default: begin
            r.kind = wsd_pkg::KIND_ERROR;
            r.error_code = wsd_pkg::ERR_OPCODE;
            got = 1'b1;
            parse_phase = wsd_pkg::PH_ERR;
         end
      endcase
   endtask

   task automatic after_length(output bit got, output wsd_pkg::result_type r);
      got = 1'b0;
      r = '0;
      if (masked) begin
         ext_left = 3'd3;
         mask_key = '0;
         parse_phase = wsd_pkg::PH_KEY;
      end else begin
         close_header(got, r);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b, output bit got,
                               output wsd_pkg::result_type r);
      logic [7:0] u;
      logic [3:0] op;
      logic       last;
      got = 1'b0;
      r = '0;
      op = hdr0[3:0];
      case (parse_phase)
         wsd_pkg::PH_HEAD1: begin
            masked = b[7];
            if (b[6:0] == wsd_pkg::LEN7_EXT16 || b[6:0] == wsd_pkg::LEN7_EXT64) begin
               ext_left = (b[6:0] == wsd_pkg::LEN7_EXT16) ? 3'd1 : 3'd7;
               pay_left = '0;
               parse_phase = wsd_pkg::PH_EXT;
            end else begin
               pay_left = {57'd0, b[6:0]};
               after_length(got, r);
            end
         end
         wsd_pkg::PH_EXT: begin
            pay_left = {pay_left[55:0], b};
            if (ext_left == 0) after_length(got, r);
            else ext_left = ext_left - 1'b1;
         end
         wsd_pkg::PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            if (ext_left == 0) close_header(got, r);
            else ext_left = ext_left - 1'b1;
         end
         wsd_pkg::PH_PAY: begin
            if (pay_left == 0) begin
               parse_phase = wsd_pkg::PH_HEAD0;
            end else begin
               u = b;
               if (masked) begin
                  u = b ^ 8'(mask_key >> (24 - 8 * int'(key_pos)));
                  key_pos = key_pos + 1'b1;
               end
               pay_left = pay_left - 1;
               last = (pay_left == 0);
               parse_phase = last ? wsd_pkg::PH_HEAD0 : wsd_pkg::PH_PAY;
               case (op)
                  wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN: begin
                     r.kind = wsd_pkg::KIND_DATA;
                     r.data_byte = u;
                     r = with_flags(r, op);
                     r.frame_last = last;
                     got = 1'b1;
                  end
                  wsd_pkg::OP_PING: begin
                     r.kind = wsd_pkg::KIND_PING;
                     r.data_byte = u;
                     r.frame_last = last;
                     got = 1'b1;
                  end
                  wsd_pkg::OP_CLOSE: begin
                     if (code_cnt == 0) begin
                        code_hi = u;
                        code_cnt = 2'd1;
                     end else if (code_cnt == 1) begin
                        code_cnt = 2'd2;
                        r.kind = wsd_pkg::KIND_CLOSE;
                        r.frame_last = last;
                        r.close_reason = {code_hi, u};
                        got = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         wsd_pkg::PH_ERR: ;
         default: begin
            hdr0 = b;
            parse_phase = wsd_pkg::PH_HEAD1;
         end
      endcase
   endtask

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic compare_result(input wsd_pkg::result_type seen);
      wsd_pkg::result_type want;
      if (deframed_pending.size() == 0) begin
         flag_mismatch($sformatf("result kind %0d with none expected", seen.kind));
      end else begin
         want = deframed_pending.pop_front();
         if (seen.kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", seen.kind, want.kind));
         if (seen.data_byte !== want.data_byte)
            flag_mismatch($sformatf("data_byte %h, want %h", seen.data_byte, want.data_byte));
         if (seen.is_binary !== want.is_binary)
            flag_mismatch($sformatf("is_binary %b, want %b", seen.is_binary, want.is_binary));
         if (seen.is_continuation !== want.is_continuation)
            flag_mismatch($sformatf("is_continuation %b, want %b",
                                    seen.is_continuation, want.is_continuation));
         if (seen.more_fragments !== want.more_fragments)
            flag_mismatch($sformatf("more_fragments %b, want %b",
                                    seen.more_fragments, want.more_fragments));
         if (seen.frame_last !== want.frame_last)
            flag_mismatch($sformatf("frame_last %b, want %b", seen.frame_last, want.frame_last));
         if (seen.close_reason !== want.close_reason)
            flag_mismatch($sformatf("close_reason %0d, want %0d",
                                    seen.close_reason, want.close_reason));
         if (seen.error_code !== want.error_code)
            flag_mismatch($sformatf("error_code %0d, want %0d", seen.error_code, want.error_code));
      end
   endtask

   // Sender: one byte per transaction, the parser prediction runs on acceptance.
   always @(posedge clock) begin : sender
      bit                  got;
      wsd_pkg::result_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte, got, r);
            if (got) deframed_pending.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (wire_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
               req_valid <= 1'b1;
               req_rx_byte <= wire_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            compare_result({rsp_kind, rsp_data_byte, rsp_is_binary, rsp_is_continuation,
                            rsp_more_fragments, rsp_frame_last, rsp_close_reason,
                            rsp_error_code});
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Form -1 picks at random among the length encodings that fit; pat -1 gives random payload.
   task automatic add_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic mask, input logic [63:0] len, input int form,
                            input int pat);
      logic [31:0] key;
      logic [63:0] n;
      int          f;
      int          pick;
      key = $urandom;
      f = form;
      if (f < 0) begin
         if (len > 65535) begin
            f = 2;
         end else if (len > 125) begin
            f = $urandom_range(1, 2);
         end else begin
            pick = $urandom_range(0, 9);
            f = (pick < 8) ? 0 : pick - 7;
         end
      end
      wire_bytes.push_back({fin, rsv, op});
      case (f)
         0: wire_bytes.push_back({mask, len[6:0]});
         1: begin
            wire_bytes.push_back({mask, wsd_pkg::LEN7_EXT16});
            wire_bytes.push_back(len[15:8]);
            wire_bytes.push_back(len[7:0]);
         end
         default: begin
            wire_bytes.push_back({mask, wsd_pkg::LEN7_EXT64});
            for (int i = 7; i >= 0; i--) wire_bytes.push_back(len[8 * i +: 8]);
         end
      endcase
      if (mask)
         for (int i = 3; i >= 0; i--) wire_bytes.push_back(key[8 * i +: 8]);
      // A huge length is only used where the header alone matters.
      n = (len > 4096) ? 64'd0 : len;
      for (int i = 0; i < int'(n); i++)
         wire_bytes.push_back((pat < 0) ? 8'($urandom) : 8'(pat));
      bytes_queued += 2 + ((f == 0) ? 0 : (f == 1) ? 2 : 8) + (mask ? 4 : 0) + int'(n);
   endtask

   task automatic add_random_frame();
      int          r;
      int          cap;
      logic [3:0]  op;
      logic [63:0] len;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         case ($urandom_range(0, 2))
            0: op = wsd_pkg::OP_CONT;
            1: op = wsd_pkg::OP_TEXT;
            default: op = wsd_pkg::OP_BIN;
         endcase
         r = $urandom_range(0, 99);
         if (r < 80) len = $urandom_range(0, 10);
         else if (r < 95) len = $urandom_range(0, 40);
         else len = $urandom_range(126, 300);
      end else if (r < 67) begin
         op = wsd_pkg::OP_CLOSE;
         len = ($urandom_range(0, 49) == 0) ? $urandom_range(126, 140) : $urandom_range(0, 6);
      end else if (r < 87) begin
         op = wsd_pkg::OP_PING;
         cap = (ping_limit < 10) ? int'(ping_limit) : 10;
         len = ($urandom_range(0, 9) == 0) ? ping_limit : $urandom_range(0, cap);
      end else begin
         op = wsd_pkg::OP_PONG;
         len = $urandom_range(0, 6);
      end
      add_frame($urandom_range(0, 4) != 0, ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0,
                op, $urandom_range(0, 1), len, -1, -1);
   endtask

   task automatic add_random_frames(input int count);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < count) add_random_frame();
   endtask

   task automatic wait_drained();
      while (wire_bytes.size() != 0 || req_valid || deframed_pending.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_ping_limit(input logic [6:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      ping_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic request_hold_midway();
      while (wire_bytes.size() > 70) @(posedge clock);
      hold_req <= hold_req + 1;
   endtask

   initial begin
      logic [3:0] bad_op;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b0, 0, 0, -1);
      add_frame(1'b0, 3'd0, wsd_pkg::OP_BIN, 1'b1, 4, 0, 8'hFF);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_CONT, 1'b0, 3, 0, 8'h00);
      add_frame(1'b1, 3'b111, wsd_pkg::OP_TEXT, 1'b0, 2, 0, -1);
      add_frame(1'b0, 3'd0, wsd_pkg::OP_CONT, 1'b1, 0, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_BIN, 1'b0, 3, 1, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b1, 2, 2, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_CLOSE, 1'b0, 0, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_CLOSE, 1'b1, 1, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_CLOSE, 1'b1, 2, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_CLOSE, 1'b0, 5, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_CLOSE, 1'b0, 126, 1, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_PING, 1'b0, 0, 0, -1);
      add_frame(1'b0, 3'd0, wsd_pkg::OP_PING, 1'b1, 3, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_PING, 1'b0, 125, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_PONG, 1'b1, 2, 0, -1);
      add_frame(1'b1, 3'd0, wsd_pkg::OP_PONG, 1'b0, 0, 0, -1);

      // With a zero limit only empty pings pass; this stretch runs without idling.
      set_ping_limit(7'd0);
      @(negedge clock);
      steady = 1'b1;
      add_random_frames(30);
      wait_drained();
      steady = 1'b0;

      set_ping_limit(wsd_pkg::LIMIT_RESET);
      @(negedge clock);
      add_random_frames(15);
      request_hold_midway();

      set_ping_limit(7'($urandom_range(1, 124)));
      @(negedge clock);
      add_random_frames(15);
      request_hold_midway();

      // The block stays in error until reset, so the one error frame comes last.
      wait_drained();
      @(negedge clock);
      if ($urandom_range(0, 1) == 0) begin
         do bad_op = 4'($urandom);
         while (bad_op inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN,
                               wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG});
         add_frame(1'b1, 3'd0, bad_op, $urandom_range(0, 1), $urandom_range(0, 5), -1, -1);
      end else begin
         add_frame(1'b1, 3'd0, wsd_pkg::OP_PING, $urandom_range(0, 1),
                   {1'b1, 63'($urandom)}, 2, -1);
      end
      repeat (12) wire_bytes.push_back(8'($urandom));

      wait_drained();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && deframed_pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
